// File: rtl/sirt_pkg.sv
// ----------------------------------------------------------------------------
// sirt_pkg: shared types and constants for the radix text converter
// Widths, character codes, register indexes and the job record that passes
// from the front end through the queue to the digit engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sirt_pkg;

  localparam int unsigned MAX_RADIX    = 16;
  localparam int unsigned VAL_W        = 32;
  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned RSIZE_W      = 5;
  localparam int unsigned NUM_SYM      = 16;
  localparam int unsigned DIGIT_W      = 4;
  localparam int unsigned MAX_DIGITS   = 32;
  localparam int unsigned DIDX_W       = $clog2(MAX_DIGITS);
  localparam int unsigned NDIG_W       = $clog2(MAX_DIGITS + 1);
  localparam int unsigned BITS_PER_CYC = 8;
  localparam int unsigned DIV_CYC      = VAL_W / BITS_PER_CYC;
  localparam int unsigned DCNT_W       = $clog2(DIV_CYC);
  localparam int unsigned QDEPTH       = 2;
  localparam int unsigned QPTR_W       = $clog2(QDEPTH);
  localparam int unsigned QCNT_W       = $clog2(QDEPTH + 1);
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 64;

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  localparam logic [CFG_IDX_W-1:0] REG_RADIX_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

  localparam logic [RSIZE_W-1:0]    RADIX_SIZE_RST   = 5'd10;
  localparam logic [CFG_DATA_W-1:0] SYMBOLS_LOW_RST  = 64'h3736353433323130;
  localparam logic [CFG_DATA_W-1:0] SYMBOLS_HIGH_RST = 64'h0000000000003938;

  // Symbol i sits in byte i.
  typedef logic [NUM_SYM-1:0][CHAR_W-1:0] alphabet_t;

  typedef struct packed {
    logic             neg;
    logic [VAL_W-1:0] mag;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

// File: rtl/sirt_front.sv
// ----------------------------------------------------------------------------
// sirt_front: input classification
// Checks the configured alphabet, takes the sign and magnitude of each
// accepted number and hands the job to the queue. Numbers that arrive while
// the alphabet is invalid are accepted and dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module sirt_front (
  input  wire logic [sirt_pkg::RSIZE_W-1:0] radix_size,
  input  wire sirt_pkg::alphabet_t          alphabet,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [sirt_pkg::VAL_W-1:0]   in_value,
  input  wire sirt_pkg::q_status_t          q_status,
  output logic                              push,
  output sirt_pkg::job_t                    push_job
);
  import sirt_pkg::*;

  logic sym_ok;
  logic size_ok;
  logic alpha_ok;

  // Only the first radix_size symbols take part in the check.
  always_comb begin
    sym_ok = 1'b1;
    for (int i = 0; i < NUM_SYM; i++) begin
      if (RSIZE_W'(i) < radix_size) begin
        if (alphabet[i] == CHAR_NUL || alphabet[i] == CHAR_PLUS ||
            alphabet[i] == CHAR_MINUS) begin
          sym_ok = 1'b0;
        end
        for (int j = i + 1; j < NUM_SYM; j++) begin
          if (RSIZE_W'(j) < radix_size && alphabet[j] == alphabet[i]) begin
            sym_ok = 1'b0;
          end
        end
      end
    end
  end

  assign size_ok  = (radix_size >= RSIZE_W'(2)) && (radix_size <= RSIZE_W'(MAX_RADIX));
  assign alpha_ok = size_ok && sym_ok;

  assign in_tready = !alpha_ok || !q_status.full;
  assign push      = in_tvalid && alpha_ok && !q_status.full;

  // The most negative value negates to 2^31, which is exact as unsigned.
  assign push_job.neg = in_value[VAL_W-1];
  assign push_job.mag = in_value[VAL_W-1] ? (VAL_W'(0) - in_value) : in_value;

endmodule

`default_nettype wire

// File: rtl/sirt_queue.sv
// ----------------------------------------------------------------------------
// sirt_queue: short job queue
// A small first-in first-out buffer that lets the front end take a new
// number while the digit engine is still busy with an earlier one.
// ----------------------------------------------------------------------------
`default_nettype none

module sirt_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire sirt_pkg::job_t push_job,
  input  wire logic           pop,
  output sirt_pkg::job_t      pop_job,
  output sirt_pkg::q_status_t q_status
);
  import sirt_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign q_status.full  = (count_r == QCNT_W'(QDEPTH));
  assign q_status.empty = (count_r == '0);
  assign pop_job        = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/sirt_back.sv
// ----------------------------------------------------------------------------
// sirt_back: digit engine and character output
// Divides the magnitude by the radix repeatedly with an iterative restoring
// divider, stores the remainders, then plays them back most significant
// first through a registered output stage, after a minus sign if negative.
// ----------------------------------------------------------------------------
`default_nettype none

module sirt_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [sirt_pkg::RSIZE_W-1:0] radix_size,
  input  wire sirt_pkg::alphabet_t          alphabet,
  input  wire sirt_pkg::q_status_t          q_status,
  input  wire sirt_pkg::job_t               pop_job,
  output logic                              pop,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [sirt_pkg::CHAR_W-1:0]       out_char,
  output logic                              out_last
);
  import sirt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t             state_r;
  logic [VAL_W-1:0]   quot_r;
  logic [DIGIT_W-1:0] rem_r;
  logic [DCNT_W-1:0]  dcnt_r;
  logic [NDIG_W-1:0]  nd_r;
  logic               sign_r;
  logic [DIGIT_W-1:0] digits_r [MAX_DIGITS];
  logic               out_valid_r;
  logic [CHAR_W-1:0]  out_char_r;
  logic               out_last_r;

  logic [VAL_W-1:0]   div_q;
  logic [DIGIT_W:0]   div_t;
  logic [DIGIT_W:0]   div_r;
  logic               div_done;
  logic               load_out;
  logic [NDIG_W-1:0]  nd_m1;

  // Eight restoring steps per cycle; the partial remainder stays below the
  // radix, so it never needs more than five bits.
  always_comb begin
    div_q = quot_r;
    div_r = {1'b0, rem_r};
    div_t = '0;
    for (int k = 0; k < BITS_PER_CYC; k++) begin
      div_t = {div_r[DIGIT_W-1:0], div_q[VAL_W-1]};
      div_q = {div_q[VAL_W-2:0], 1'b0};
      if (div_t >= radix_size) begin
        div_t    = div_t - radix_size;
        div_q[0] = 1'b1;
      end
      div_r = div_t;
    end
  end

  assign div_done = (dcnt_r == DCNT_W'(DIV_CYC - 1));
  assign load_out = !out_valid_r || out_tready;
  assign nd_m1    = nd_r - NDIG_W'(1);
  assign pop      = (state_r == ST_IDLE) && !q_status.empty;

  assign out_tvalid = out_valid_r;
  assign out_char   = out_char_r;
  assign out_last   = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      nd_r        <= '0;
      dcnt_r      <= '0;
      sign_r      <= 1'b0;
    end else begin
      // While emitting, a free output slot is always refilled below.
      if (out_tready && state_r != ST_EMIT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (!q_status.empty) begin
            quot_r  <= pop_job.mag;
            sign_r  <= pop_job.neg;
            rem_r   <= '0;
            dcnt_r  <= '0;
            nd_r    <= '0;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          quot_r <= div_q;
          if (div_done) begin
            digits_r[nd_r[DIDX_W-1:0]] <= div_r[DIGIT_W-1:0];
            nd_r   <= nd_r + NDIG_W'(1);
            rem_r  <= '0;
            dcnt_r <= '0;
            if (div_q == '0) begin
              state_r <= ST_EMIT;
            end
          end else begin
            rem_r  <= div_r[DIGIT_W-1:0];
            dcnt_r <= dcnt_r + DCNT_W'(1);
          end
        end
        ST_EMIT: begin
          if (load_out) begin
            out_valid_r <= 1'b1;
            if (sign_r) begin
              out_char_r <= CHAR_MINUS;
              out_last_r <= 1'b0;
              sign_r     <= 1'b0;
            end else begin
              out_char_r <= alphabet[digits_r[nd_m1[DIDX_W-1:0]]];
              out_last_r <= (nd_r == NDIG_W'(1));
              nd_r       <= nd_m1;
              if (nd_r == NDIG_W'(1)) begin
                state_r <= ST_IDLE;
              end
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/signed_integer_to_radix_text.sv
// Path: a number accepted into an idle block goes through the queue, the
// divider and the output register; the divider retires eight quotient bits
// per cycle. The engine takes a new number only once the last character of
// the previous one is in the output register; the queue buffers up to two.
// Reset (rst_n low, synchronous): queue and engine empty, radix 10, "0".."9".
// ----------------------------------------------------------------------------
// signed_integer_to_radix_text: signed integer to text in a chosen radix
// Converts each signed 32-bit number to its text, most significant digit
// first, using a configurable alphabet of up to sixteen symbols.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_integer_to_radix_text (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Input stream: one number per beat.
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [sirt_pkg::VAL_W-1:0]      in_tdata,   // [31:0] value
  // Output stream: one character per beat.
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [sirt_pkg::CHAR_W-1:0]          out_tdata,  // [7:0] character
  output logic                                 out_tlast,
  // Register write port.
  input  wire logic                            cfg_wen,
  input  wire logic [sirt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sirt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sirt_pkg::*;

  // Configuration registers: change them only while the block is idle; the
  // block does not check. Both halves of the design read them directly.
  logic [RSIZE_W-1:0]    radix_size_r;
  logic [CFG_DATA_W-1:0] symbols_low_r;
  logic [CFG_DATA_W-1:0] symbols_high_r;
  alphabet_t             alphabet;

  // Hand-off between the front end and the digit engine.
  q_status_t q_status;
  logic      push;
  job_t      push_job;
  logic      pop;
  job_t      pop_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_size_r   <= RADIX_SIZE_RST;
      symbols_low_r  <= SYMBOLS_LOW_RST;
      symbols_high_r <= SYMBOLS_HIGH_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_RADIX_SIZE:   radix_size_r   <= cfg_data[RSIZE_W-1:0];
        REG_SYMBOLS_LOW:  symbols_low_r  <= cfg_data;
        REG_SYMBOLS_HIGH: symbols_high_r <= cfg_data;
        default: begin
          // Writes to unused indexes are ignored.
        end
      endcase
    end
  end

  // Symbols 0 to 7 come from the low word, 8 to 15 from the high word.
  assign alphabet = {symbols_high_r, symbols_low_r};

  // The front end checks the alphabet on every beat; when it is invalid the
  // number is taken and produces no characters at all.
  sirt_front u_front (
    .radix_size (radix_size_r),
    .alphabet   (alphabet),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_value   (in_tdata),
    .q_status   (q_status),
    .push       (push),
    .push_job   (push_job)
  );

  // A two-entry queue decouples input acceptance from conversion.
  sirt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .q_status (q_status)
  );

  // The digit engine owns the output register, which holds a character
  // while the sink stalls; the queue keeps taking numbers until it is full.
  sirt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .radix_size (radix_size_r),
    .alphabet   (alphabet),
    .q_status   (q_status),
    .pop_job    (pop_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_char   (out_tdata),
    .out_last   (out_tlast)
  );

endmodule

`default_nettype wire
